// ===== rtl/bfa_pkg.sv =====
// shared codes and field width for the best-fit block allocator
package bfa_pkg;

    localparam int FIELD_W = 13;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_INVALID = 2'd2,
        ST_RSVD    = 2'd3
    } status_t;

endpackage

// ===== rtl/best_fit_block_allocator.sv =====
// best-fit block allocator: address-ordered block table in one synchronous ram, with coalescing
//
// One request is taken at a time and answered with one result. The block table
// (header offset, payload size, used flag per block) sits in a single ram with a
// registered read; a sequencer walks it. Cost per request grows with the number of
// table entries N: a search reads the entries in turn, splitting a block shifts the
// entries above it up, and a merge shifts them down. A reallocate that has to move
// does three searches, a split and up to three merges. After reset the S_INIT state
// writes the initial whole-pool block before the first request is taken. A result
// waits in an output register while the next request is accepted.
module best_fit_block_allocator #(
    parameter int POOL_BYTES   = 4096,
    parameter int HEADER_BYTES = 32,
    parameter int MAX_BLOCKS   = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // block_address[12:0], request_size[25:13], zero fill
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // result_address[12:0], copy_from[25:13],
                                        // copy_bytes[38:26], zero fill
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int FW = bfa_pkg::FIELD_W;
    localparam int AW = $clog2(POOL_BYTES + 1);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int KW = CW + 1;
    localparam int XW = (AW > FW) ? AW : FW;
    localparam int SW = XW + 1;

    typedef struct packed {
        logic          used;
        logic [AW-1:0] off;
        logic [AW-1:0] size;
    } entry_t;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_SCAN, S_FREE_CHK,
        S_REL0, S_REL1, S_REL2, S_REL3, S_REL4,
        S_GRANT_CHK, S_GRANT_SPL, S_GRANT_USE, S_MOVE_CHK,
        S_RE_CHK, S_RE1, S_RE2, S_RE3,
        S_SP0, S_SP1, S_SP2, S_SP3, S_SP4,
        S_MG0, S_MG1, S_MG2, S_MG3, S_DONE
    } state_t;

    // block table
    entry_t mem [MAX_BLOCKS];
    entry_t q_reg;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          we;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= (we && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
        end
    end

    state_t        state_reg, state_next;
    state_t        ret_reg, ret_next;
    state_t        mret_reg, mret_next;
    logic [CW-1:0] count_reg, count_next;
    logic [KW-1:0] i_reg, i_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] m_reg, m_next;
    logic          found_reg, found_next;
    logic          best_mode_reg, best_mode_next;
    logic          mv_reg, mv_next;
    logic          rd_pend_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [AW-1:0] best_size_reg, best_size_next;
    logic [AW-1:0] old_size_reg, old_size_next;
    entry_t        gk_reg, gk_next;
    entry_t        sk_reg, sk_next;
    entry_t        mk_reg, mk_next;
    logic [FW-1:0] addr_reg, addr_next;
    logic [FW-1:0] n_reg, n_next;
    logic [FW-1:0] res_reg, res_next;
    bfa_pkg::status_t status_reg, status_next;
    logic [FW-1:0] cfrom_reg, cfrom_next;
    logic [FW-1:0] cbytes_reg, cbytes_next;
    logic          m_valid_reg, m_valid_next;
    logic [FW-1:0] o_res_reg, o_res_next;
    bfa_pkg::status_t o_status_reg, o_status_next;
    logic [FW-1:0] o_cfrom_reg, o_cfrom_next;
    logic [FW-1:0] o_cbytes_reg, o_cbytes_next;

    logic [KW-1:0] kx, k1, k2, cnt_x, mx;
    logic [SW-1:0] n_x, addr_x, q_size_x, q_payload_x;
    logic          find_hit, fit_hit, split_ok;

    assign kx          = KW'(k_reg);
    assign k1          = kx + KW'(1);
    assign k2          = kx + KW'(2);
    assign mx          = KW'(m_reg);
    assign cnt_x       = KW'(count_reg);
    assign n_x         = SW'(n_reg);
    assign addr_x      = SW'(addr_reg);
    assign q_size_x    = SW'(q_reg.size);
    assign q_payload_x = SW'(q_reg.off) + SW'(HEADER_BYTES);
    assign find_hit    = q_reg.used && (q_payload_x == addr_x);
    assign fit_hit     = !q_reg.used && (q_size_x >= n_x);
    assign split_ok    = (q_size_x >= n_x + SW'(HEADER_BYTES))
                         && (count_reg < CW'(MAX_BLOCKS));

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, o_cbytes_reg, o_cfrom_reg, o_res_reg};
    assign m_axis_tuser  = o_status_reg;

    always_comb
    begin
        logic [FW-1:0] in_addr;
        logic [FW-1:0] in_n;
        logic [1:0]    in_op;
        logic          issue;
        logic [KW-1:0] ra;
        logic [KW-1:0] wa;
        logic [SW-1:0] sum;

        in_addr = s_axis_tdata[FW-1:0];
        in_n    = s_axis_tdata[2*FW-1:FW];
        in_op   = s_axis_tuser;
        issue   = 1'b0;
        ra      = kx;
        wa      = kx;
        sum     = '0;

        state_next     = state_reg;
        ret_next       = ret_reg;
        mret_next      = mret_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        found_next     = found_reg;
        best_mode_next = best_mode_reg;
        mv_next        = mv_reg;
        best_size_next = best_size_reg;
        old_size_next  = old_size_reg;
        gk_next        = gk_reg;
        sk_next        = sk_reg;
        mk_next        = mk_reg;
        addr_next      = addr_reg;
        n_next         = n_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        cfrom_next     = cfrom_reg;
        cbytes_next    = cbytes_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        o_res_next     = o_res_reg;
        o_status_next  = o_status_reg;
        o_cfrom_next   = o_cfrom_reg;
        o_cbytes_next  = o_cbytes_reg;

        rd_en   = 1'b0;
        we      = 1'b0;
        wr_data = q_reg;

        case (state_reg)
            S_INIT:
            begin
                we         = 1'b1;
                wa         = '0;
                wr_data    = '{used: 1'b0, off: '0, size: AW'(POOL_BYTES - HEADER_BYTES)};
                count_next = CW'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    addr_next   = in_addr;
                    n_next      = in_n;
                    res_next    = '0;
                    status_next = bfa_pkg::ST_OK;
                    cfrom_next  = '0;
                    cbytes_next = '0;
                    mv_next     = 1'b0;
                    i_next      = '0;
                    found_next  = 1'b0;
                    if (in_op == bfa_pkg::OP_ALLOC
                        || (in_op == bfa_pkg::OP_REALLOC && in_addr == '0))
                    begin
                        best_mode_next = 1'b1;
                        ret_next       = S_GRANT_CHK;
                        state_next     = S_SCAN;
                    end
                    else if (in_op == bfa_pkg::OP_FREE
                             || (in_op == bfa_pkg::OP_REALLOC && in_n == '0))
                    begin
                        best_mode_next = 1'b0;
                        ret_next       = S_FREE_CHK;
                        state_next     = S_SCAN;
                    end
                    else if (in_op == bfa_pkg::OP_REALLOC)
                    begin
                        best_mode_next = 1'b0;
                        ret_next       = S_RE_CHK;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        status_next = bfa_pkg::ST_INVALID;
                        state_next  = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                // one entry read per cycle, compare on the registered read data
                if (rd_pend_reg)
                begin
                    if (best_mode_reg)
                    begin
                        if (fit_hit && (!found_reg || q_reg.size < best_size_reg))
                        begin
                            found_next     = 1'b1;
                            k_next         = rd_idx_reg;
                            best_size_next = q_reg.size;
                        end
                    end
                    else if (!found_reg && find_hit)
                    begin
                        found_next = 1'b1;
                        k_next     = rd_idx_reg;
                    end
                end
                issue = (i_reg < cnt_x) && (best_mode_reg || !found_next);
                if (issue)
                begin
                    rd_en  = 1'b1;
                    ra     = i_reg;
                    i_next = i_reg + KW'(1);
                end
                else if (!rd_pend_reg)
                begin
                    state_next = ret_reg;
                end
            end
            S_FREE_CHK:
            begin
                if (found_reg)
                begin
                    state_next = S_REL0;
                end
                else
                begin
                    status_next = bfa_pkg::ST_INVALID;
                    state_next  = S_DONE;
                end
            end
            S_REL0:
            begin
                rd_en      = 1'b1;
                ra         = kx;
                state_next = S_REL1;
            end
            S_REL1:
            begin
                we           = 1'b1;
                wa           = kx;
                wr_data      = q_reg;
                wr_data.used = 1'b0;
                if (k1 < cnt_x)
                begin
                    rd_en      = 1'b1;
                    ra         = k1;
                    state_next = S_REL2;
                end
                else
                begin
                    state_next = S_REL3;
                end
            end
            S_REL2:
            begin
                if (!q_reg.used)
                begin
                    m_next     = k_reg;
                    mret_next  = S_REL3;
                    state_next = S_MG0;
                end
                else
                begin
                    state_next = S_REL3;
                end
            end
            S_REL3:
            begin
                if (k_reg != '0)
                begin
                    rd_en      = 1'b1;
                    ra         = kx - KW'(1);
                    state_next = S_REL4;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_REL4:
            begin
                if (!q_reg.used)
                begin
                    m_next     = k_reg - IW'(1);
                    mret_next  = S_DONE;
                    state_next = S_MG0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_GRANT_CHK:
            begin
                if (found_reg)
                begin
                    rd_en      = 1'b1;
                    ra         = kx;
                    state_next = S_GRANT_SPL;
                end
                else
                begin
                    res_next    = '0;
                    status_next = bfa_pkg::ST_OOM;
                    state_next  = S_DONE;
                end
            end
            S_GRANT_SPL:
            begin
                gk_next.used = 1'b1;
                gk_next.off  = q_reg.off;
                gk_next.size = split_ok ? AW'(n_x) : q_reg.size;
                res_next     = q_payload_x[FW-1:0];
                ret_next     = S_GRANT_USE;
                state_next   = S_SP0;
            end
            S_GRANT_USE:
            begin
                we      = 1'b1;
                wa      = kx;
                wr_data = gk_reg;
                if (mv_reg)
                begin
                    // block moved: find the old one again, its index may have shifted
                    i_next         = '0;
                    found_next     = 1'b0;
                    best_mode_next = 1'b0;
                    ret_next       = S_MOVE_CHK;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MOVE_CHK:
            begin
                if (found_reg)
                begin
                    cfrom_next  = addr_reg;
                    cbytes_next = old_size_reg[FW-1:0];
                    state_next  = S_REL0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RE_CHK:
            begin
                if (found_reg)
                begin
                    rd_en      = 1'b1;
                    ra         = kx;
                    state_next = S_RE1;
                end
                else
                begin
                    status_next = bfa_pkg::ST_INVALID;
                    state_next  = S_DONE;
                end
            end
            S_RE1:
            begin
                old_size_next = q_reg.size;
                if (n_x <= q_size_x)
                begin
                    res_next   = addr_reg;
                    ret_next   = S_DONE;
                    state_next = S_SP0;
                end
                else if (k1 < cnt_x)
                begin
                    rd_en      = 1'b1;
                    ra         = k1;
                    state_next = S_RE2;
                end
                else
                begin
                    mv_next        = 1'b1;
                    i_next         = '0;
                    found_next     = 1'b0;
                    best_mode_next = 1'b1;
                    ret_next       = S_GRANT_CHK;
                    state_next     = S_SCAN;
                end
            end
            S_RE2:
            begin
                sum = SW'(old_size_reg) + SW'(HEADER_BYTES) + q_size_x;
                if (!q_reg.used && sum >= n_x)
                begin
                    res_next   = addr_reg;
                    m_next     = k_reg;
                    mret_next  = S_RE3;
                    state_next = S_MG0;
                end
                else
                begin
                    mv_next        = 1'b1;
                    i_next         = '0;
                    found_next     = 1'b0;
                    best_mode_next = 1'b1;
                    ret_next       = S_GRANT_CHK;
                    state_next     = S_SCAN;
                end
            end
            S_RE3:
            begin
                rd_en      = 1'b1;
                ra         = kx;
                ret_next   = S_DONE;
                state_next = S_SP0;
            end
            S_SP0:
            begin
                // q_reg holds entry k
                if (split_ok)
                begin
                    sk_next    = q_reg;
                    i_next     = cnt_x - KW'(1);
                    state_next = S_SP1;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            S_SP1:
            begin
                // open a slot at k+1: copy entries upward, highest first
                if (rd_pend_reg)
                begin
                    we      = 1'b1;
                    wa      = KW'(rd_idx_reg) + KW'(1);
                    wr_data = q_reg;
                end
                issue = (i_reg >= k1);
                if (issue)
                begin
                    rd_en  = 1'b1;
                    ra     = i_reg;
                    i_next = i_reg - KW'(1);
                end
                else if (!rd_pend_reg)
                begin
                    state_next = S_SP2;
                end
            end
            S_SP2:
            begin
                we   = 1'b1;
                wa   = k1;
                sum  = SW'(sk_reg.off) + SW'(HEADER_BYTES) + n_x;
                wr_data.used = 1'b0;
                wr_data.off  = sum[AW-1:0];
                sum  = SW'(sk_reg.size) - n_x - SW'(HEADER_BYTES);
                wr_data.size = sum[AW-1:0];
                count_next   = count_reg + CW'(1);
                state_next   = S_SP3;
            end
            S_SP3:
            begin
                we           = 1'b1;
                wa           = kx;
                wr_data.used = sk_reg.used;
                wr_data.off  = sk_reg.off;
                wr_data.size = AW'(n_x);
                if (k2 < cnt_x)
                begin
                    rd_en      = 1'b1;
                    ra         = k2;
                    state_next = S_SP4;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            S_SP4:
            begin
                if (!q_reg.used)
                begin
                    m_next     = k1[IW-1:0];
                    mret_next  = ret_reg;
                    state_next = S_MG0;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end
            S_MG0:
            begin
                rd_en      = 1'b1;
                ra         = mx;
                state_next = S_MG1;
            end
            S_MG1:
            begin
                mk_next    = q_reg;
                rd_en      = 1'b1;
                ra         = mx + KW'(1);
                state_next = S_MG2;
            end
            S_MG2:
            begin
                we           = 1'b1;
                wa           = mx;
                sum          = SW'(mk_reg.size) + SW'(HEADER_BYTES) + q_size_x;
                wr_data.used = mk_reg.used;
                wr_data.off  = mk_reg.off;
                wr_data.size = sum[AW-1:0];
                i_next       = mx + KW'(2);
                state_next   = S_MG3;
            end
            S_MG3:
            begin
                // close the gap at m+1: copy entries downward, lowest first
                if (rd_pend_reg)
                begin
                    we      = 1'b1;
                    wa      = KW'(rd_idx_reg) - KW'(1);
                    wr_data = q_reg;
                end
                issue = (i_reg < cnt_x);
                if (issue)
                begin
                    rd_en  = 1'b1;
                    ra     = i_reg;
                    i_next = i_reg + KW'(1);
                end
                else if (!rd_pend_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = mret_reg;
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    o_res_next    = res_reg;
                    o_status_next = status_reg;
                    o_cfrom_next  = cfrom_reg;
                    o_cbytes_next = cbytes_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_addr = ra[IW-1:0];
        wr_addr = wa[IW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ret_reg       <= S_IDLE;
            mret_reg      <= S_IDLE;
            count_reg     <= CW'(1);
            i_reg         <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
            found_reg     <= 1'b0;
            best_mode_reg <= 1'b0;
            mv_reg        <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            mret_reg      <= mret_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
            found_reg     <= found_next;
            best_mode_reg <= best_mode_next;
            mv_reg        <= mv_next;
            rd_pend_reg   <= rd_en;
            rd_idx_reg    <= rd_addr;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_size_reg <= best_size_next;
        old_size_reg  <= old_size_next;
        gk_reg        <= gk_next;
        sk_reg        <= sk_next;
        mk_reg        <= mk_next;
        addr_reg      <= addr_next;
        n_reg         <= n_next;
        res_reg       <= res_next;
        status_reg    <= status_next;
        cfrom_reg     <= cfrom_next;
        cbytes_reg    <= cbytes_next;
        o_res_reg     <= o_res_next;
        o_status_reg  <= o_status_next;
        o_cfrom_reg   <= o_cfrom_next;
        o_cbytes_reg  <= o_cbytes_next;
    end

    // table never empties and never overflows
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CW'(MAX_BLOCKS)))
        else $error("block count out of range");

    // only live entries are ever read
    a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (KW'(rd_addr) < cnt_x))
        else $error("read beyond table end");

    // writes stay at or below the table end
    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (KW'(wr_addr) <= cnt_x))
        else $error("write beyond table end");

    // an accepted request always starts the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != S_IDLE))
        else $error("request accepted without work");

    // a loaded result is presented next cycle
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!m_valid_reg || m_axis_tready)) |=> m_axis_tvalid)
        else $error("result lost");

endmodule
